// ----- rtl/core/rne_pkg.sv -----
// Roman numeral encoder: shared types, constants and the numeral term table.
// Used by rne_ctrl, rne_dp, roman_numeral_encoder and rne_checker.
// No dependencies.
`default_nettype none

package rne_pkg;

	localparam int VALUE_W           = 12;
	localparam int SYM_W             = 8;
	localparam int MAX_THOUSANDS_DEF = 3;
	localparam int RESULT_LIMIT      = 15;
	localparam int CNT_W             = $clog2(RESULT_LIMIT + 1);
	localparam int NUM_TERMS         = 13;

	localparam logic [SYM_W-1:0] SYM_I = 8'h49;
	localparam logic [SYM_W-1:0] SYM_V = 8'h56;
	localparam logic [SYM_W-1:0] SYM_X = 8'h58;
	localparam logic [SYM_W-1:0] SYM_L = 8'h4C;
	localparam logic [SYM_W-1:0] SYM_C = 8'h43;
	localparam logic [SYM_W-1:0] SYM_D = 8'h44;
	localparam logic [SYM_W-1:0] SYM_M = 8'h4D;

	typedef enum logic [0:0] {
		RNE_IDLE,
		RNE_RUN
	} rne_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} rne_cmd_t;

	typedef struct packed {
		logic done;
	} rne_stat_t;

	// Greedy term table, largest first; pair terms emit sym0 then sym1.
	localparam logic [VALUE_W-1:0] TERM_WEIGHT [NUM_TERMS] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};
	localparam logic [SYM_W-1:0] TERM_SYM0 [NUM_TERMS] = '{
		SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
		SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I
	};
	localparam logic [SYM_W-1:0] TERM_SYM1 [NUM_TERMS] = '{
		SYM_M, SYM_M, SYM_D, SYM_D, SYM_C, SYM_C, SYM_L,
		SYM_L, SYM_X, SYM_X, SYM_V, SYM_V, SYM_I
	};
	localparam logic TERM_PAIR [NUM_TERMS] = '{
		1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
	};

endpackage

`default_nettype wire

// ----- rtl/core/roman_numeral_encoder.sv -----
// Roman numeral encoder top level: controller plus datapath.
// Depends on rne_pkg, rne_ctrl and rne_dp.
// First letter: the taken request loads the value and enters run, then the
//   first step registers the letter on symbol with strobe.
// Throughput: one letter per cycle; busy covers the emit steps plus one done
//   check, and a new request is taken only back in idle (3888 is the longest).
// The rate is set by the single emit step of the datapath, one letter per cycle.
// Reset: arst_n clears the state machine, the pending flag and the strobe at once.
`default_nettype none

module roman_numeral_encoder #(
	parameter int MAX_THOUSANDS = rne_pkg::MAX_THOUSANDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rne_pkg::VALUE_W-1:0] value,
	output logic                             busy,
	output logic [rne_pkg::SYM_W-1:0]        symbol,
	output logic                             last,
	output logic                             strobe
);
	import rne_pkg::*;

	rne_cmd_t  cmd;
	rne_stat_t stat;

	// Sequence the request: load on start, step one letter a cycle until done.
	rne_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold the remaining value and emit letters greedily, largest term first.
	rne_dp #(
		.MAX_THOUSANDS (MAX_THOUSANDS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.cmd    (cmd),
		.stat   (stat),
		.symbol (symbol),
		.last   (last),
		.strobe (strobe)
	);

endmodule

`default_nettype wire

// ----- rtl/core/rne_ctrl.sv -----
// Roman numeral encoder controller: idle/run state machine.
// Depends on rne_pkg.
`default_nettype none

module rne_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  rne_pkg::rne_stat_t     stat,
	output rne_pkg::rne_cmd_t      cmd,
	output logic                   busy
);
	import rne_pkg::*;

	rne_state_t state_q;
	rne_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RNE_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b0;
		case (state_q)
			RNE_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = RNE_RUN;
				end
			end
			RNE_RUN: begin
				busy = 1'b1;
				if (stat.done) begin
					state_nx = RNE_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_nx = RNE_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/rne_dp.sv -----
// Roman numeral encoder datapath: remaining value, pending second letter,
// greedy term select and the registered result. Depends on rne_pkg.
`default_nettype none

module rne_dp #(
	parameter int MAX_THOUSANDS = rne_pkg::MAX_THOUSANDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [rne_pkg::VALUE_W-1:0] value,
	input  rne_pkg::rne_cmd_t                cmd,
	output rne_pkg::rne_stat_t               stat,
	output logic [rne_pkg::SYM_W-1:0]        symbol,
	output logic                             last,
	output logic                             strobe
);
	import rne_pkg::*;

	localparam int unsigned LIMIT = MAX_THOUSANDS * 1000 + 999;

	logic [VALUE_W-1:0] v_q;
	logic               pend_q;
	logic [SYM_W-1:0]   pend_sym_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SYM_W-1:0]   symbol_q;
	logic               last_q;
	logic               strobe_q;

	logic [VALUE_W-1:0] v_sat;
	logic [VALUE_W-1:0] sel_w;
	logic [SYM_W-1:0]   sel_s0;
	logic [SYM_W-1:0]   sel_s1;
	logic               sel_pair;
	logic [VALUE_W-1:0] v_nx;
	logic               pend_nx;
	logic [SYM_W-1:0]   sym_nx;
	logic               last_nx;

	// Clamp to the largest encodable value.
	assign v_sat = (32'(value) > LIMIT) ? VALUE_W'(LIMIT) : value;

	// Largest term not above the remaining value; index 0 wins last.
	always_comb begin
		sel_w    = '0;
		sel_s0   = TERM_SYM0[NUM_TERMS-1];
		sel_s1   = TERM_SYM1[NUM_TERMS-1];
		sel_pair = 1'b0;
		for (int i = NUM_TERMS - 1; i >= 0; i--) begin
			if (v_q >= TERM_WEIGHT[i]) begin
				sel_w    = TERM_WEIGHT[i];
				sel_s0   = TERM_SYM0[i];
				sel_s1   = TERM_SYM1[i];
				sel_pair = TERM_PAIR[i];
			end
		end
	end

	always_comb begin
		if (pend_q) begin
			sym_nx  = pend_sym_q;
			v_nx    = v_q;
			pend_nx = 1'b0;
		end else begin
			sym_nx  = sel_s0;
			v_nx    = v_q - sel_w;
			pend_nx = sel_pair;
		end
		last_nx = ((v_nx == '0) && !pend_nx) || (cnt_q == CNT_W'(RESULT_LIMIT - 1));
	end

	assign stat.done = (v_q == '0) && !pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
			if (cmd.load) begin
				pend_q <= 1'b0;
				cnt_q  <= '0;
			end else if (cmd.step) begin
				pend_q <= pend_nx && !last_nx;
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= v_sat;
		end else if (cmd.step) begin
			v_q        <= last_nx ? '0 : v_nx;
			pend_sym_q <= sel_s1;
			symbol_q   <= sym_nx;
			last_q     <= last_nx;
		end
	end

	assign symbol = symbol_q;
	assign last   = last_q;
	assign strobe = strobe_q;

endmodule

`default_nettype wire

// ----- rtl/core/rne_checker.sv -----
// Roman numeral encoder port checker and its bind to the top level.
// Depends on rne_pkg and roman_numeral_encoder.
`default_nettype none

module rne_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic [rne_pkg::VALUE_W-1:0] value,
	input wire logic                        busy,
	input wire logic [rne_pkg::SYM_W-1:0]   symbol,
	input wire logic                        last,
	input wire logic                        strobe
);
	import rne_pkg::*;

	logic unused_ok;
	assign unused_ok = ^value;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken but busy not raised");

	a_letter: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (symbol == SYM_I || symbol == SYM_V || symbol == SYM_X ||
		symbol == SYM_L || symbol == SYM_C || symbol == SYM_D || symbol == SYM_M))
		else $error("strobe with a non-numeral letter");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe) else $error("letter right after last");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe) else $error("gap inside a numeral");

	a_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("letter without a request in work");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.value  (value),
	.busy   (busy),
	.symbol (symbol),
	.last   (last),
	.strobe (strobe)
);

`default_nettype wire
